// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the bip buffer region manager.
// No dependencies; the macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication from a trigger condition to a consequence in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst, trig, cons, msg)
`endif
`endif

// ===== rtl/bbrm_pkg.sv =====
// Types and constants of the bip buffer region manager.
// Used by bbrm_op_logic and the top level; depends on nothing.
package bbrm_pkg;

  localparam int ADDR_W = 12;
  localparam int SIZE_W = 13;
  localparam int CALC_W = 14;

  typedef logic [CALC_W-1:0] calc_t;

  typedef enum logic [2:0] {
    FUNC_WRITE  = 3'd0,
    FUNC_COMMIT = 3'd1,
    FUNC_READ   = 3'd2,
    FUNC_REMOVE = 3'd3,
    FUNC_QUERY  = 3'd4
  } func_t;

  typedef struct packed {
    logic [2:0]        func;
    logic [SIZE_W-1:0] length;
  } in_word_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] seg1_addr;
    logic [SIZE_W-1:0] seg1_len;
    logic [ADDR_W-1:0] seg2_addr;
    logic [SIZE_W-1:0] seg2_len;
    logic [ADDR_W-1:0] move_from;
    logic [SIZE_W-1:0] move_len;
    logic [SIZE_W-1:0] data_size;
    logic [SIZE_W-1:0] contiguous_len;
    logic [SIZE_W-1:0] free_space;
    logic [ADDR_W-1:0] start_addr;
  } out_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] a_start;
    logic [SIZE_W-1:0] a_size;
    logic              b_active;
    logic [ADDR_W-1:0] b_start;
    logic [SIZE_W-1:0] b_size;
  } region_t;

endpackage

// ===== rtl/bbrm_op_logic.sv =====
// Combinational operation logic: next region state and result word for one operation.
// Depends on bbrm_pkg.
module bbrm_op_logic import bbrm_pkg::*; (
  input  region_t                cur,
  input  logic [SIZE_W-1:0]      eff_size,
  input  in_word_t               item,
  output region_t                nxt,
  output out_word_t              res
);

  always_comb begin
    calc_t a_st, a_sz, b_st, b_sz, eff, len;
    calc_t free_a, free_b, free_b_w, b_base, b_sz_w, room, n, held;
    calc_t t1, t2, cnt, a_st1, a_sz1, b_st1, b_sz1;
    calc_t s1a, s1l, s2a, s2l, mvf, mvl;
    calc_t na_st, na_sz, nb_st, nb_sz, nfree_a, nfree_b, fs;
    logic  do_alloc, bact, ok;

    a_st = CALC_W'(cur.a_start);
    a_sz = CALC_W'(cur.a_size);
    b_st = CALC_W'(cur.b_start);
    b_sz = CALC_W'(cur.b_size);
    eff  = CALC_W'(eff_size);
    len  = CALC_W'(item.length);
    free_a = (eff > a_st + a_sz) ? eff - (a_st + a_sz) : '0;
    free_b = (a_st > b_st + b_sz) ? a_st - (b_st + b_sz) : '0;
    do_alloc = !cur.b_active && (free_a < a_st);
    bact     = cur.b_active || do_alloc;
    free_b_w = do_alloc ? a_st : free_b;
    b_base   = do_alloc ? '0 : b_st + b_sz;
    b_sz_w   = do_alloc ? '0 : b_sz;
    room  = cur.b_active ? free_b : free_a;
    n     = (len > room) ? room : len;
    held  = a_sz + b_sz;
    t1    = (len > a_sz) ? a_sz : len;
    cnt   = len - t1;
    t2    = (cnt != '0 && b_sz != '0) ? ((cnt > b_sz) ? b_sz : cnt) : '0;
    a_sz1 = a_sz - t1;
    a_st1 = a_st + t1;
    b_sz1 = b_sz - t2;
    b_st1 = b_st + t2;

    nxt = cur;
    ok  = 1'b0;
    s1a = '0;
    s1l = '0;
    s2a = '0;
    s2l = '0;
    mvf = '0;
    mvl = '0;

    if (eff != '0) begin
      unique case (item.func)
        FUNC_WRITE: begin
          if (do_alloc) begin
            nxt.b_active = 1'b1;
            nxt.b_start  = '0;
            nxt.b_size   = '0;
          end
          if (bact) begin
            if (free_b_w >= len) begin
              ok = 1'b1;
              s1a = b_base;
              s1l = len;
              nxt.b_size = SIZE_W'(b_sz_w + len);
            end
          end else if (free_a >= len) begin
            ok = 1'b1;
            s1a = a_st + a_sz;
            s1l = len;
            nxt.a_size = SIZE_W'(a_sz + len);
          end
        end
        FUNC_COMMIT: begin
          ok  = (len <= room);
          s1l = n;
          if (cur.b_active) begin
            s1a = (n != '0) ? b_st + b_sz : '0;
            nxt.b_size = SIZE_W'(b_sz + n);
          end else begin
            s1a = (n != '0) ? a_st + a_sz : '0;
            nxt.a_size = SIZE_W'(a_sz + n);
          end
        end
        FUNC_READ, FUNC_REMOVE: begin
          ok = (held >= len);
          if (item.func == FUNC_REMOVE || held >= len) begin
            s1a = (t1 != '0) ? a_st : '0;
            s1l = t1;
            s2a = (t2 != '0) ? b_st : '0;
            s2l = t2;
            if (a_sz1 == '0) begin
              if (cur.b_active && b_sz1 != '0) begin
                if (b_st1 != '0) begin
                  mvf = b_st1;
                  mvl = b_sz1;
                end
                nxt = '0;
                nxt.a_size = SIZE_W'(b_sz1);
              end else begin
                nxt = '0;
              end
            end else begin
              nxt.a_start = ADDR_W'(a_st1);
              nxt.a_size  = SIZE_W'(a_sz1);
              nxt.b_start = ADDR_W'(b_st1);
              nxt.b_size  = SIZE_W'(b_sz1);
            end
          end
        end
        FUNC_QUERY: begin
          ok = 1'b1;
          if (do_alloc) begin
            nxt.b_active = 1'b1;
            nxt.b_start  = '0;
            nxt.b_size   = '0;
          end
        end
        default: begin
        end
      endcase
    end

    na_st = CALC_W'(nxt.a_start);
    na_sz = CALC_W'(nxt.a_size);
    nb_st = CALC_W'(nxt.b_start);
    nb_sz = CALC_W'(nxt.b_size);
    nfree_a = (eff > na_st + na_sz) ? eff - (na_st + na_sz) : '0;
    nfree_b = (na_st > nb_st + nb_sz) ? na_st - (nb_st + nb_sz) : '0;
    if (nxt.b_active) begin
      fs = nfree_b;
    end else begin
      fs = (nfree_a < na_st) ? na_st : nfree_a;
    end

    res.ok             = ok;
    res.seg1_addr      = ADDR_W'(s1a);
    res.seg1_len       = SIZE_W'(s1l);
    res.seg2_addr      = ADDR_W'(s2a);
    res.seg2_len       = SIZE_W'(s2l);
    res.move_from      = ADDR_W'(mvf);
    res.move_len       = SIZE_W'(mvl);
    res.data_size      = SIZE_W'(na_sz + nb_sz);
    res.contiguous_len = (nxt.a_size != '0) ? nxt.a_size : nxt.b_size;
    res.free_space     = SIZE_W'(fs);
    res.start_addr     = (nxt.a_size != '0) ? nxt.a_start : nxt.b_start;
  end

endmodule

// ===== rtl/bip_buffer_region_manager_unit.sv =====
// Top level of the bip buffer region manager: input register, region state, result register.
// Depends on bbrm_pkg, bbrm_op_logic and assert_macros.svh.
//
//   Channel   Signals                          Carries
//   in        in_valid / in_ready / in_data    one operation word (func, length)
//   out       out_valid / out_ready / out_data one result word per operation
//   cfg       cfg_valid / cfg_ready / cfg_data buffer size in bytes
//
// An accepted operation passes through the input register, where the region state is read
// and updated, and then through the result register. One operation is accepted per cycle
// while the result is not stalled; the region update is a single pass of adds and compares.
// Reset is synchronous and empties both regions and sets the buffer size to zero.
// A stalled result holds the result register, and the input register fills behind it.
`include "assert_macros.svh"
module bip_buffer_region_manager_unit import bbrm_pkg::*; #(
  parameter int BUF_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam logic [31:0] BufBytesW = 32'(BUF_BYTES);

  logic [SIZE_W-1:0] eff_size;
  logic [SIZE_W-1:0] eff_size_next;
  region_t           region;
  region_t           region_next;
  logic              stage_valid;
  in_word_t          stage_item;
  out_word_t         result;
  logic              adv;

  bbrm_op_logic u_op_logic (
    .cur      (region),
    .eff_size (eff_size),
    .item     (stage_item),
    .nxt      (region_next),
    .res      (result)
  );

  assign adv           = stage_valid && (!out_valid || out_ready);
  assign in_ready      = !stage_valid || adv;
  assign cfg_ready     = 1'b1;
  assign eff_size_next = (32'(cfg_data) > BufBytesW) ? BufBytesW[SIZE_W-1:0] : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_size    <= '0;
      region      <= '0;
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        eff_size <= eff_size_next;
        region   <= '0;
      end else if (adv) begin
        region <= region_next;
      end
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
    if (adv) begin
      out_data <= result;
    end
  end

  `ASSERT_IMPLY(a_empty_a_at_zero, clk, rst, region.a_size == '0, region.a_start == '0 && !region.b_active, "Empty region A must sit at offset zero with no region B")
  `ASSERT_IMPLY(a_b_below_a, clk, rst, region.b_active, (CALC_W'(region.b_start) + CALC_W'(region.b_size)) <= CALC_W'(region.a_start), "Region B must end at or before the start of region A")
  `ASSERT_IMPLY(a_no_b_is_zero, clk, rst, !region.b_active, region.b_start == '0 && region.b_size == '0, "Inactive region B must be cleared")
  `ASSERT_IMPLY(a_stall_blocks_input, clk, rst, stage_valid && out_valid && !out_ready, !in_ready, "A word must not be taken while the full pipeline is stalled")

endmodule
